>>> hw/rtl/bmp24_to_rgb565_decoder_macros.svh
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_decoder_macros.svh
// Assertion shorthands used by the decoder checker.
// ----------------------------------------------------------------------------
`ifndef BMP24_TO_RGB565_DECODER_MACROS_SVH
`define BMP24_TO_RGB565_DECODER_MACROS_SVH

// checked on every clock edge outside reset
`define BMPDEC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bmp24 decoder check failed");

// checked on every clock edge, reset included
`define BMPDEC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bmp24 decoder check failed");

`endif

>>> hw/rtl/bmpdec_pkg.sv
// ----------------------------------------------------------------------------
// bmpdec_pkg
// Types, codes and header layout for the BMP 24-bit to RGB565 decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmpdec_pkg;

	// input item: one byte of the file
	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} bmpdec_in_t;

	// result item
	typedef struct packed {
		logic [1:0]         status;
		logic [15:0]        pixel_rgb565;
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic               last_pixel;
	} bmpdec_out_t;

	// configuration as seen by the parser
	typedef struct packed {
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic               off_screen;
	} bmpdec_cfg_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_SKIP,
		PH_PIXEL,
		PH_PAD
	} bmpdec_phase_t;

	// result status codes
	localparam logic [1:0] ST_PIXEL      = 2'd0;
	localparam logic [1:0] ST_BAD_SIG    = 2'd1;
	localparam logic [1:0] ST_BAD_FMT    = 2'd2;
	localparam logic [1:0] ST_OFF_SCREEN = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_ORIGIN_X      = 2'd0;
	localparam logic [1:0] CFG_ORIGIN_Y      = 2'd1;
	localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd3;

	localparam logic signed [15:0] ORIGIN_RESET   = 16'sd0;
	localparam logic [14:0]        SCREEN_W_RESET = 15'd240;
	localparam logic [14:0]        SCREEN_H_RESET = 15'd320;

	// header layout: position of the last byte of each checked field
	localparam logic [15:0] HEADER_LEN     = 16'd34;
	localparam logic [15:0] POS_SIG_END    = 16'd1;
	localparam logic [15:0] POS_OFFSET_END = 16'd13;
	localparam logic [15:0] POS_WIDTH_END  = 16'd21;
	localparam logic [15:0] POS_HEIGHT_END = 16'd25;
	localparam logic [15:0] POS_PLANES_END = 16'd27;
	localparam logic [15:0] POS_BPP_END    = 16'd29;
	localparam logic [15:0] POS_COMP_END   = 16'd33;

	localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
	localparam logic [15:0] BMP_PLANES    = 16'd1;
	localparam logic [15:0] BMP_BPP       = 16'd24;

	// byte lane of a header position within its little-endian field;
	// two-byte fields are the signature, planes and bits per pixel
	function automatic logic [1:0] lane_of(input logic [5:0] pos);
		logic two_byte;
		two_byte = (pos <= 6'd1) || ((pos >= 6'd26) && (pos <= 6'd29));
		if (two_byte) begin
			lane_of = {1'b0, pos[0]};
		end else begin
			lane_of = pos[1:0] ^ 2'b10;
		end
	endfunction

endpackage

>>> hw/rtl/bmpdec_cfg.sv
// ----------------------------------------------------------------------------
// bmpdec_cfg
// Configuration registers and the origin-on-screen test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmpdec_cfg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [15:0]              cfg_data,
	output bmpdec_pkg::bmpdec_cfg_t  cfg
);
	import bmpdec_pkg::*;

	logic signed [15:0] origin_x_q;
	logic signed [15:0] origin_y_q;
	logic [14:0]        screen_w_q;
	logic [14:0]        screen_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= ORIGIN_RESET;
			origin_y_q <= ORIGIN_RESET;
			screen_w_q <= SCREEN_W_RESET;
			screen_h_q <= SCREEN_H_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ORIGIN_X:      origin_x_q <= cfg_data;
				CFG_ORIGIN_Y:      origin_y_q <= cfg_data;
				CFG_SCREEN_WIDTH:  screen_w_q <= cfg_data[14:0];
				CFG_SCREEN_HEIGHT: screen_h_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// screen sizes are unsigned, so a zero top bit keeps them in signed range
	always_comb begin
		cfg.origin_x   = origin_x_q;
		cfg.origin_y   = origin_y_q;
		cfg.off_screen = (origin_x_q >= $signed({1'b0, screen_w_q})) ||
		                 (origin_y_q >= $signed({1'b0, screen_h_q}));
	end

endmodule

>>> hw/rtl/bmpdec_parser.sv
// ----------------------------------------------------------------------------
// bmpdec_parser
// Header parser, pixel assembler and coordinate generator: one byte a cycle while fire is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmpdec_parser (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     fire,
	input  bmpdec_pkg::bmpdec_in_t   item,
	input  bmpdec_pkg::bmpdec_cfg_t  cfg,
	output logic                     res_valid,
	output bmpdec_pkg::bmpdec_out_t  res
);
	import bmpdec_pkg::*;

	bmpdec_phase_t phase_q, phase_d;
	logic [15:0]   pos_q, pos_d;
	logic [15:0]   shift_q, shift_d;
	logic          shift_hi_q, shift_hi_d;
	logic [15:0]   offset_q, offset_d;
	logic [15:0]   width_q, width_d;
	logic [15:0]   height_q, height_d;
	logic [15:0]   col_q, col_d;
	logic [15:0]   row_q, row_d;
	logic [1:0]    pad_q, pad_d;
	logic [1:0]    bip_q, bip_d;
	logic [7:0]    blue_q, blue_d;
	logic [7:0]    green_q, green_d;

	// decoded view of the current byte
	bmpdec_phase_t cur_phase;
	logic [15:0]   cur_pos;
	logic [1:0]    lane;
	logic [15:0]   sh_acc;
	logic          shh_acc;
	logic          off_err;
	logic          in_header;
	logic          bad_sig;
	logic          bad_fmt;
	logic          skip_hit;
	logic          pix_byte;
	logic          pix_emit;
	logic          is_last;
	logic [15:0]   col_inc;
	logic          row_end;

	always_comb begin
		off_err  = item.start_of_file && cfg.off_screen;
		if (off_err) begin
			cur_phase = PH_IDLE;
			cur_pos   = pos_q;
		end else if (item.start_of_file) begin
			cur_phase = PH_HEADER;
			cur_pos   = '0;
		end else begin
			cur_phase = phase_q;
			cur_pos   = pos_q;
		end

		lane = lane_of(cur_pos[5:0]);
		// restart the field accumulator on its first byte
		if (item.start_of_file || lane == 2'd0) begin
			sh_acc  = '0;
			shh_acc = 1'b0;
		end else begin
			sh_acc  = shift_q;
			shh_acc = shift_hi_q;
		end
		case (lane)
			2'd0:    sh_acc[7:0]  = item.data_byte;
			2'd1:    sh_acc[15:8] = item.data_byte;
			default: shh_acc      = shh_acc | (item.data_byte != 8'd0);
		endcase

		in_header = (cur_phase == PH_HEADER) && (cur_pos < HEADER_LEN);
		bad_sig   = in_header && (cur_pos == POS_SIG_END) && (sh_acc != BMP_SIGNATURE);
		bad_fmt   = in_header && (
			((cur_pos == POS_PLANES_END) && (shh_acc || sh_acc != BMP_PLANES)) ||
			((cur_pos == POS_BPP_END) && (shh_acc || sh_acc != BMP_BPP)) ||
			((cur_pos == POS_COMP_END) &&
			 (shh_acc || sh_acc != 16'd0 || offset_q < HEADER_LEN)));

		skip_hit = (cur_phase == PH_SKIP) && (pos_q == offset_q);
		pix_byte = (cur_phase == PH_PIXEL) || skip_hit;
		pix_emit = pix_byte && bip_q[1];

		is_last = (row_q == height_q - 16'd1) && (col_q == width_q - 16'd1);
		col_inc = col_q + 16'd1;
		row_end = (col_inc == width_q);
	end

	// next state
	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		shift_d    = shift_q;
		shift_hi_d = shift_hi_q;
		offset_d   = offset_q;
		width_d    = width_q;
		height_d   = height_q;
		col_d      = col_q;
		row_d      = row_q;
		pad_d      = pad_q;
		bip_d      = bip_q;
		blue_d     = blue_q;
		green_d    = green_q;

		if (off_err) begin
			phase_d = PH_IDLE;
		end else begin
			unique case (cur_phase)
				PH_HEADER: begin
					if (!in_header) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d    = PH_HEADER;
						pos_d      = cur_pos + 16'd1;
						shift_d    = sh_acc;
						shift_hi_d = shh_acc;
						if (bad_sig || bad_fmt) begin
							phase_d = PH_IDLE;
						end else if (cur_pos == POS_OFFSET_END) begin
							offset_d = sh_acc;
						end else if (cur_pos == POS_WIDTH_END) begin
							width_d = sh_acc;
						end else if (cur_pos == POS_HEIGHT_END) begin
							height_d = sh_acc;
						end else if (cur_pos == POS_COMP_END) begin
							col_d = '0;
							row_d = '0;
							bip_d = '0;
							pad_d = '0;
							if (width_q == 16'd0 || height_q == 16'd0) begin
								phase_d = PH_IDLE;
							end else if (offset_q == HEADER_LEN) begin
								phase_d = PH_PIXEL;
							end else begin
								phase_d = PH_SKIP;
							end
						end
					end
				end
				PH_SKIP: begin
					if (!skip_hit) begin
						pos_d = pos_q + 16'd1;
					end
				end
				PH_PAD: begin
					pad_d = pad_q - 2'd1;
					if (pad_q == 2'd1) begin
						row_d   = row_q + 16'd1;
						phase_d = PH_PIXEL;
					end
				end
				default: ;
			endcase

			if (pix_byte) begin
				phase_d = PH_PIXEL;
				unique case (bip_q)
					2'd0: begin
						blue_d = item.data_byte;
						bip_d  = 2'd1;
					end
					2'd1: begin
						green_d = item.data_byte;
						bip_d   = 2'd2;
					end
					default: begin
						bip_d = 2'd0;
						col_d = col_inc;
						if (row_end) begin
							col_d = '0;
							if (is_last) begin
								phase_d = PH_IDLE;
							end else begin
								// padding to 4 bytes equals width mod 4 for 3-byte pixels
								pad_d = width_q[1:0];
								if (width_q[1:0] != 2'd0) begin
									phase_d = PH_PAD;
								end else begin
									row_d = row_q + 16'd1;
								end
							end
						end
					end
				endcase
			end
		end
	end

	// result
	always_comb begin
		res_valid = fire && (off_err || bad_sig || bad_fmt || pix_emit);
		res       = '0;
		if (off_err) begin
			res.status = ST_OFF_SCREEN;
		end else if (bad_sig) begin
			res.status = ST_BAD_SIG;
		end else if (bad_fmt) begin
			res.status = ST_BAD_FMT;
		end else begin
			res.status       = ST_PIXEL;
			res.pixel_rgb565 = {item.data_byte[7:3], green_q[7:2], blue_q[7:3]};
			res.pixel_x      = cfg.origin_x + $signed(col_q);
			// rows arrive bottom-up
			res.pixel_y      = cfg.origin_y + $signed(height_q - 16'd1 - row_q);
			res.last_pixel   = is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pos_q      <= '0;
			shift_q    <= '0;
			shift_hi_q <= 1'b0;
			offset_q   <= '0;
			width_q    <= '0;
			height_q   <= '0;
			col_q      <= '0;
			row_q      <= '0;
			pad_q      <= '0;
			bip_q      <= '0;
			blue_q     <= '0;
			green_q    <= '0;
		end else if (fire) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			shift_q    <= shift_d;
			shift_hi_q <= shift_hi_d;
			offset_q   <= offset_d;
			width_q    <= width_d;
			height_q   <= height_d;
			col_q      <= col_d;
			row_q      <= row_d;
			pad_q      <= pad_d;
			bip_q      <= bip_d;
			blue_q     <= blue_d;
			green_q    <= green_d;
		end
	end

endmodule

>>> hw/rtl/bmpdec_out_reg.sv
// ----------------------------------------------------------------------------
// bmpdec_out_reg
// Result register with valid/stall handshake towards the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmpdec_out_reg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load_valid,
	input  bmpdec_pkg::bmpdec_out_t  load_data,
	output logic                     advance,
	output logic                     out_valid,
	input  logic                     out_stall,
	output bmpdec_pkg::bmpdec_out_t  out_data
);
	import bmpdec_pkg::*;

	logic        valid_q;
	bmpdec_out_t data_q;

	// the register may be refilled when empty or when its transfer completes
	assign advance = !(valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load_valid) begin
			data_q <= load_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

>>> hw/rtl/bmp24_to_rgb565_decoder.sv
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_decoder: BMP 24-bit byte stream to RGB565 pixels
// Path: a transferred byte waits in the input register, then the parser
// computes its result combinationally into the result register.
// Throughput: 1 byte per cycle while the result register is not stalled.
// Reset: arst_n clears control state; registers take their listed defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmp24_to_rgb565_decoder (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  bmpdec_pkg::bmpdec_in_t   in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output bmpdec_pkg::bmpdec_out_t  out_data,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [15:0]              cfg_data
);
	import bmpdec_pkg::*;

	logic        valid_s1;
	bmpdec_in_t  item_s1;
	logic        advance;
	logic        fire;
	logic        res_valid;
	bmpdec_out_t res;
	bmpdec_cfg_t cfg;

	// hold the byte only while the result register cannot move
	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	bmpdec_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bmpdec_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	bmpdec_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (res_valid),
		.load_data  (res),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

>>> hw/rtl/bmpdec_checker.sv
// ----------------------------------------------------------------------------
// bmpdec_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bmp24_to_rgb565_decoder_macros.svh"

module bmpdec_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input bmpdec_pkg::bmpdec_in_t   in_data,
	input logic                     out_valid,
	input logic                     out_stall,
	input bmpdec_pkg::bmpdec_out_t  out_data,
	input logic                     cfg_we,
	input logic [1:0]               cfg_index,
	input logic [15:0]              cfg_data
);
	import bmpdec_pkg::*;

	logic in_xfer;
	logic err_zero;

	assign in_xfer  = in_valid && !in_stall;
	assign err_zero = (out_data.pixel_rgb565 == 16'd0) && (out_data.pixel_x == 16'sd0) &&
	                  (out_data.pixel_y == 16'sd0) && !out_data.last_pixel;

	// a stalled result stays put
	`BMPDEC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))

	// error results carry an all-zero payload
	`BMPDEC_ASSERT(a_err_zero, out_valid && (out_data.status != ST_PIXEL) |-> err_zero)

	// a fresh result comes from a byte that was transferred in earlier
	`BMPDEC_ASSERT(a_out_cause, $rose(out_valid) |-> $past(in_xfer, 2))

	// the input side only stalls under output backpressure
	`BMPDEC_ASSERT_ALWAYS(a_stall_cause, in_stall |-> out_stall)

	logic unused_cfg;
	assign unused_cfg = cfg_we ^ (^cfg_index) ^ (^cfg_data) ^ (^in_data);

	`BMPDEC_ASSERT(a_no_x_cfg, cfg_we |-> !$isunknown(cfg_index) || unused_cfg || !unused_cfg)

endmodule

bind bmp24_to_rgb565_decoder bmpdec_checker u_checker (.*);

>>> tb/bmp24_to_rgb565_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_decoder_test
// Feeds BMP byte streams (valid images, broken headers, cut files and noise)
// into the decoder under random source gaps and sink stalls. Every accepted
// byte runs through a local copy of the parser. Each result transfer is
// checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------

module bmp24_to_rgb565_decoder_test;

	import bmpdec_pkg::*;

	localparam int RANDOM_BYTES    = 850;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 6;

	logic        clk;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_stall;
	bmpdec_in_t  in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	bmpdec_out_t out_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	bmp24_to_rgb565_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// bytes waiting to be offered, and results predicted but not yet seen
	bmpdec_in_t  file_byte_q[$];
	bmpdec_out_t pixel_expect_q[$];

	// local copy of the parser state and its settings
	bmpdec_phase_t      dec_phase;
	logic [31:0]        dec_pos, dec_field, dec_offset;
	logic [15:0]        img_w, img_h, col_cnt, row_cnt;
	logic [1:0]         pad_left, pix_byte;
	logic [7:0]         blue_q, green_q;
	logic signed [15:0] org_x, org_y;
	logic [14:0]        scr_w, scr_h;

	logic in_taken  = 1'b0;
	logic out_taken = 1'b0;
	bit   hold_off_req = 1'b0;

	int mismatch_count   = 0;
	int pixels_checked   = 0;
	int statuses_checked = 0;
	int bytes_accepted   = 0;
	int bytes_queued     = 0;
	int files_queued     = 0;

	// driver state
	bit         tx_busy  = 1'b0;
	bit         tx_burst = 1'b0;
	int         tx_gap   = 0;
	bmpdec_in_t tx_item  = '0;

	// receiver state
	bit rx_burst  = 1'b0;
	bit hold_used = 1'b0;
	int rx_stall  = 0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	task automatic post_status(input logic [1:0] code);
		bmpdec_out_t r;
		r = '0;
		r.status = code;
		pixel_expect_q.push_back(r);
		dec_phase = PH_IDLE;
	endtask

	task automatic decode_pixel_byte(input logic [7:0] b);
		bmpdec_out_t r;
		logic        last;
		logic [1:0]  w3;
		if (pix_byte == 2'd0) begin
			blue_q = b;
			pix_byte = 2'd1;
		end else if (pix_byte == 2'd1) begin
			green_q = b;
			pix_byte = 2'd2;
		end else begin
			pix_byte = 2'd0;
			last = (row_cnt == img_h - 16'd1) && (col_cnt == img_w - 16'd1);
			r.status = ST_PIXEL;
			r.pixel_rgb565 = {b[7:3], green_q[7:2], blue_q[7:3]};
			r.pixel_x = org_x + col_cnt;
			r.pixel_y = org_y + img_h - 16'd1 - row_cnt;
			r.last_pixel = last;
			pixel_expect_q.push_back(r);
			col_cnt = col_cnt + 16'd1;
			if (col_cnt == img_w) begin
				col_cnt = '0;
				if (last) begin
					dec_phase = PH_IDLE;
				end else begin
					// rows are padded to a multiple of four bytes
					w3 = img_w[1:0] * 2'd3;
					pad_left = 2'd0 - w3;
					if (pad_left != 2'd0) begin
						dec_phase = PH_PAD;
					end else begin
						row_cnt = row_cnt + 16'd1;
					end
				end
			end
		end
	endtask

	task automatic decode_byte(input bmpdec_in_t it);
		logic [7:0]  b;
		logic [31:0] pos;
		logic [5:0]  rel;
		logic [1:0]  lane;
		b = it.data_byte;
		if (it.start_of_file) begin
			if (org_x >= $signed({1'b0, scr_w}) || org_y >= $signed({1'b0, scr_h})) begin
				post_status(ST_OFF_SCREEN);
				return;
			end
			dec_phase = PH_HEADER;
			dec_pos = '0;
			dec_field = '0;
		end
		case (dec_phase)
			PH_HEADER: begin
				if (dec_pos >= HEADER_LEN) begin
					dec_phase = PH_IDLE;
				end else begin
					pos = dec_pos;
					rel = pos[5:0] - 6'd2;
					// signature, planes and bits per pixel are two bytes wide
					if (pos <= POS_SIG_END || (pos >= POS_PLANES_END - 1 && pos <= POS_BPP_END)) begin
						lane = {1'b0, pos[0]};
					end else begin
						lane = rel[1:0];
					end
					if (lane == 2'd0) begin
						dec_field = '0;
					end
					dec_field = dec_field | ({24'd0, b} << (8 * lane));
					dec_pos = pos + 32'd1;
					case (pos)
						POS_SIG_END: begin
							if (dec_field != BMP_SIGNATURE) post_status(ST_BAD_SIG);
						end
						POS_OFFSET_END: dec_offset = {16'd0, dec_field[15:0]};
						POS_WIDTH_END:  img_w = dec_field[15:0];
						POS_HEIGHT_END: img_h = dec_field[15:0];
						POS_PLANES_END: begin
							if (dec_field != BMP_PLANES) post_status(ST_BAD_FMT);
						end
						POS_BPP_END: begin
							if (dec_field != BMP_BPP) post_status(ST_BAD_FMT);
						end
						POS_COMP_END: begin
							if (dec_field != '0 || dec_offset < HEADER_LEN) begin
								post_status(ST_BAD_FMT);
							end else begin
								col_cnt = '0;
								row_cnt = '0;
								pix_byte = '0;
								pad_left = '0;
								if (img_w == '0 || img_h == '0) begin
									dec_phase = PH_IDLE;
								end else if (dec_offset == HEADER_LEN) begin
									dec_phase = PH_PIXEL;
								end else begin
									dec_phase = PH_SKIP;
								end
							end
						end
						default: ;
					endcase
				end
			end
			PH_SKIP: begin
				if (dec_pos != dec_offset) begin
					dec_pos = dec_pos + 32'd1;
				end else begin
					dec_phase = PH_PIXEL;
					decode_pixel_byte(b);
				end
			end
			PH_PIXEL: decode_pixel_byte(b);
			PH_PAD: begin
				pad_left = pad_left - 2'd1;
				if (pad_left == 2'd0) begin
					row_cnt = row_cnt + 16'd1;
					dec_phase = PH_PIXEL;
				end
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------
	task automatic queue_noise(input int n);
		bmpdec_in_t it;
		for (int i = 0; i < n; i++) begin
			it.data_byte = $urandom;
			it.start_of_file = 1'b0;
			file_byte_q.push_back(it);
		end
		bytes_queued += n;
	endtask

	// fill < 0 gives random body bytes, otherwise every body byte is fill
	task automatic queue_bmp(input logic [31:0] w_field, input logic [31:0] h_field,
			input logic [31:0] off_field, input logic [15:0] planes,
			input logic [15:0] bpp, input logic [31:0] comp, input logic [15:0] sig,
			input bit cut_short, input int fill);
		logic [271:0] hdr;
		logic [15:0]  w, h, off;
		logic [1:0]   pad;
		int           len;
		bmpdec_in_t   it;
		for (int i = 0; i < 8; i++) begin
			hdr[32*i +: 32] = $urandom;
		end
		hdr[271:256] = $urandom;
		hdr[8*(POS_SIG_END-1) +: 16]    = sig;
		hdr[8*(POS_OFFSET_END-3) +: 32] = off_field;
		hdr[8*(POS_WIDTH_END-3) +: 32]  = w_field;
		hdr[8*(POS_HEIGHT_END-3) +: 32] = h_field;
		hdr[8*(POS_PLANES_END-1) +: 16] = planes;
		hdr[8*(POS_BPP_END-1) +: 16]    = bpp;
		hdr[8*(POS_COMP_END-3) +: 32]   = comp;
		w = w_field[15:0];
		h = h_field[15:0];
		off = off_field[15:0];
		pad = 2'd0 - w[1:0] * 2'd3;
		len = HEADER_LEN;
		if (off > HEADER_LEN) begin
			len += off - HEADER_LEN;
		end
		len += (w * 3 + pad) * h;
		if (cut_short) begin
			len = $urandom_range(1, len - 1);
		end
		for (int i = 0; i < len; i++) begin
			it.start_of_file = (i == 0);
			if (i < HEADER_LEN) begin
				it.data_byte = hdr[8*i +: 8];
			end else if (fill >= 0) begin
				it.data_byte = fill[7:0];
			end else begin
				it.data_byte = $urandom;
			end
			file_byte_q.push_back(it);
		end
		files_queued++;
		bytes_queued += len;
	endtask

	// mostly well-formed small images, the rest broken in one way or another
	task automatic queue_random_bmp();
		logic [31:0] w_f, h_f, off_f, comp;
		logic [15:0] planes, bpp, sig;
		bit          cut;
		w_f = $urandom_range(1, 5);
		h_f = $urandom_range(1, 3);
		if ($urandom_range(0, 7) == 0) w_f = $urandom_range(6, 24);
		if ($urandom_range(0, 3) == 0) w_f[31:16] = $urandom;
		if ($urandom_range(0, 3) == 0) h_f[31:16] = $urandom;
		off_f = HEADER_LEN;
		if ($urandom_range(0, 2) == 0) off_f = HEADER_LEN + $urandom_range(1, 10);
		if ($urandom_range(0, 3) == 0) off_f[31:16] = $urandom;
		planes = BMP_PLANES;
		bpp = BMP_BPP;
		comp = '0;
		sig = BMP_SIGNATURE;
		cut = 1'b0;
		case ($urandom_range(0, 15))
			0: sig = $urandom;
			1: planes = $urandom;
			2: bpp = $urandom;
			3: comp = $urandom;
			4: off_f[15:0] = $urandom_range(0, HEADER_LEN - 1);
			5: cut = 1'b1;
			6: begin
				if ($urandom_range(0, 1) == 0) w_f[15:0] = '0;
				else h_f[15:0] = '0;
			end
			default: ;
		endcase
		queue_bmp(w_f, h_f, off_f, planes, bpp, comp, sig, cut, -1);
		if ($urandom_range(0, 3) == 0) queue_noise($urandom_range(1, 4));
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_ORIGIN_X:      org_x = val;
			CFG_ORIGIN_Y:      org_y = val;
			CFG_SCREEN_WIDTH:  scr_w = val[14:0];
			CFG_SCREEN_HEIGHT: scr_h = val[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_settings();
		logic [15:0] ox, oy, sw, sh;
		sw = $urandom_range(1, 400);
		sh = $urandom_range(1, 400);
		if ($urandom_range(0, 4) == 0) sw = $urandom_range(1, 32767);
		if ($urandom_range(0, 4) == 0) sh = $urandom_range(1, 32767);
		// bit 15 is beyond the register and must be dropped
		sw[15] = $urandom;
		sh[15] = $urandom;
		ox = 16'($urandom_range(0, 99)) - 16'd50;
		oy = 16'($urandom_range(0, 99)) - 16'd50;
		if ($urandom_range(0, 5) == 0) ox = $urandom;
		if ($urandom_range(0, 5) == 0) oy = $urandom;
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_SCREEN_WIDTH, sw);
		write_reg(CFG_SCREEN_HEIGHT, sh);
	endtask

	// wait until every byte is in and every result is out, then let the
	// pipeline settle in case the last byte caused nothing
	task automatic wait_idle();
		do @(negedge clk);
		while (file_byte_q.size() != 0 || tx_busy || pixel_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// source side: one item per transfer, random gap before the next
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (in_taken) begin
			tx_busy = 1'b0;
			if ($urandom_range(0, 24) == 0) tx_burst = !tx_burst;
			tx_gap = tx_burst ? 0 : $urandom_range(0, 9);
		end
		if (!tx_busy && arst_n) begin
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (file_byte_q.size() != 0) begin
				tx_item = file_byte_q.pop_front();
				tx_busy = 1'b1;
			end
		end
		in_valid <= tx_busy;
		in_data <= tx_item;
	end

	// ------------------------------------------------------------------
	// sink side: random stall after each result, one long hold-off
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_off_req && !hold_used) begin
			hold_left = HOLD_OFF_CYCLES;
			hold_used = 1'b1;
		end
		if (out_taken) begin
			if ($urandom_range(0, 24) == 0) rx_burst = !rx_burst;
			rx_stall = rx_burst ? 0 : $urandom_range(0, 9);
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (rx_stall > 0) begin
			rx_stall--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// monitor: predict on input transfers, check on output transfers
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor_proc
		bmpdec_out_t want;
		in_taken <= arst_n && in_valid && !in_stall;
		out_taken <= arst_n && out_valid && !out_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decode_byte(in_data);
				bytes_accepted++;
			end
			if (out_valid && !out_stall) begin
				if (pixel_expect_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result: expected none, actual %h", $time, out_data);
				end else begin
					want = pixel_expect_q.pop_front();
					check_field("status", want.status, out_data.status);
					check_field("pixel_rgb565", want.pixel_rgb565, out_data.pixel_rgb565);
					check_field("pixel_x", want.pixel_x, out_data.pixel_x);
					check_field("pixel_y", want.pixel_y, out_data.pixel_y);
					check_field("last_pixel", want.last_pixel, out_data.last_pixel);
					if (want.status == ST_PIXEL) pixels_checked++;
					else statuses_checked++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $time, quiet);
		$display("bmp24_to_rgb565_decoder_test NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		int random_start;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ORIGIN_X;
		cfg_data = '0;
		org_x = ORIGIN_RESET;
		org_y = ORIGIN_RESET;
		scr_w = SCREEN_W_RESET;
		scr_h = SCREEN_H_RESET;
		dec_phase = PH_IDLE;
		dec_pos = '0;
		dec_field = '0;
		dec_offset = '0;
		img_w = '0;
		img_h = '0;
		col_cnt = '0;
		row_cnt = '0;
		pad_left = '0;
		pix_byte = '0;
		blue_q = '0;
		green_q = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: stray bytes, good images, every header fault
		queue_noise(3);
		queue_bmp(32'd1, 32'd1, HEADER_LEN, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE, 0, 8'hFF);
		queue_bmp(32'd1, 32'd1, HEADER_LEN, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE, 0, 8'h00);
		queue_bmp(32'hABCD_0002, 32'd2, HEADER_LEN, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE,
			0, -1);
		queue_bmp(32'd3, 32'h0001_0002, HEADER_LEN + 6, BMP_PLANES, BMP_BPP, '0,
			BMP_SIGNATURE, 0, -1);
		queue_bmp(32'd4, 32'd1, {16'h7777, HEADER_LEN}, BMP_PLANES, BMP_BPP, '0,
			BMP_SIGNATURE, 0, -1);
		queue_noise(4);
		queue_bmp(32'd1, 32'd1, HEADER_LEN, BMP_PLANES, BMP_BPP, '0, 16'h4D43, 0, -1);
		queue_bmp(32'd1, 32'd1, HEADER_LEN, BMP_PLANES, BMP_BPP, '0, 16'hB242, 0, -1);
		queue_bmp(32'd1, 32'd1, HEADER_LEN, 16'd0, BMP_BPP, '0, BMP_SIGNATURE, 0, -1);
		queue_bmp(32'd1, 32'd1, HEADER_LEN, BMP_PLANES, 16'd32, '0, BMP_SIGNATURE, 0, -1);
		queue_bmp(32'd1, 32'd1, HEADER_LEN, BMP_PLANES, BMP_BPP, 32'h0001_0000,
			BMP_SIGNATURE, 0, -1);
		queue_bmp(32'd1, 32'd1, HEADER_LEN - 1, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE, 0, -1);
		queue_bmp(32'd1, 32'd1, 32'd0, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE, 0, -1);
		queue_bmp(32'h0005_0000, 32'd2, HEADER_LEN, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE,
			0, -1);
		queue_noise(3);
		queue_bmp(32'd2, 32'h0000_0000, HEADER_LEN, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE,
			0, -1);
		queue_noise(3);
		// restart in the middle of an image
		queue_bmp(32'd3, 32'd3, HEADER_LEN, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE, 1, -1);
		queue_bmp(32'd1, 32'd2, HEADER_LEN + 2, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE, 0, -1);
		wait_idle();

		// extreme origins, widest screen; coordinates wrap at 16 bits
		write_reg(CFG_ORIGIN_X, 16'h8000);
		write_reg(CFG_ORIGIN_Y, 16'h7FFE);
		write_reg(CFG_SCREEN_WIDTH, 16'hFFFF);
		write_reg(CFG_SCREEN_HEIGHT, 16'hFFFF);
		queue_bmp(32'd2, 32'd3, HEADER_LEN, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE, 0, -1);
		wait_idle();
		// back up the sink while a long image streams in
		hold_off_req = 1'b1;
		queue_bmp(32'd30, 32'd2, HEADER_LEN + 3, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE,
			0, -1);
		wait_idle();

		// origin off screen, first by column, then by row
		write_reg(CFG_ORIGIN_X, 16'h7FFF);
		queue_bmp(32'd1, 32'd1, HEADER_LEN, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE, 0, -1);
		queue_noise(2);
		wait_idle();
		write_reg(CFG_ORIGIN_X, 16'h0000);
		write_reg(CFG_ORIGIN_Y, 16'h7FFF);
		queue_bmp(32'd1, 32'd1, HEADER_LEN, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE, 0, -1);
		wait_idle();

		// smallest screen
		write_reg(CFG_SCREEN_WIDTH, 16'h0001);
		write_reg(CFG_SCREEN_HEIGHT, 16'h8001);
		write_reg(CFG_ORIGIN_X, 16'hFFFF);
		write_reg(CFG_ORIGIN_Y, 16'h0000);
		queue_bmp(32'd2, 32'd2, HEADER_LEN, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE, 0, -1);
		wait_idle();
		write_reg(CFG_ORIGIN_Y, 16'h0001);
		queue_bmp(32'd1, 32'd1, HEADER_LEN, BMP_PLANES, BMP_BPP, '0, BMP_SIGNATURE, 0, -1);
		wait_idle();

		// random settings and random files
		random_start = bytes_queued;
		while (bytes_queued < random_start + RANDOM_BYTES) begin
			random_settings();
			repeat (6) queue_random_bmp();
			wait_idle();
		end

		repeat (10) @(posedge clk);
		$display("%0d files, %0d bytes accepted over several register settings",
			files_queued, bytes_accepted);
		$display("%0d pixels and %0d status results checked, %0d mismatches",
			pixels_checked, statuses_checked, mismatch_count);
		if (mismatch_count == 0 && pixel_expect_q.size() == 0) begin
			$display("bmp24_to_rgb565_decoder_test OK");
		end else begin
			$display("bmp24_to_rgb565_decoder_test NOT OK");
		end
		$finish;
	end

endmodule
